@@ hdl/qpht_pkg.sv @@
// Shared types and constants for the quadratic probing hash table.
// Used by qpht_mod and the top level; depends on nothing else.
package qpht_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int KEY_W        = 31;
    localparam int SLOT_FIELD_W = 4;
    localparam int STATUS_W     = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd3;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_FIELD_W-1:0] slot;
    } t_out;

endpackage

@@ hdl/qpht_mod.sv @@
// Home slot unit: reduces a key modulo SLOTS by multiplying with a constant
// reciprocal, registering the quotient's low bits and then the remainder.
// Depends on qpht_pkg for the key width.
module qpht_mod #(
    parameter int SLOTS = qpht_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [qpht_pkg::KEY_W-1:0]      i_key,
    output logic                            o_done,
    output logic [$clog2(SLOTS)-1:0]        o_home
);
    import qpht_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int SH = KEY_W + AW;
    localparam int MW = KEY_W + 2;
    localparam int PW = KEY_W + MW;
    localparam logic [63:0]   MAG_FULL = ((64'd1 << SH) + 64'(SLOTS - 1)) / 64'(SLOTS);
    localparam logic [MW-1:0] MAG      = MAG_FULL[MW-1:0];
    localparam logic [AW-1:0] SLOTS_LO = AW'(SLOTS);

    logic [PW-1:0] prod;
    logic [AW-1:0] qs_lo;
    logic [AW-1:0] r_qlo;
    logic [AW-1:0] r_klo;
    logic [AW-1:0] r_rem;
    logic          r_busy;
    logic          r_done;

    // The quotient is exact for every key; only its low bits are needed,
    // since the remainder is below SLOTS.
    always_comb begin
        prod  = PW'(i_key) * PW'(MAG);
        qs_lo = r_qlo * SLOTS_LO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_qlo  <= prod[SH +: AW];
                r_klo  <= i_key[AW-1:0];
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= r_klo - qs_lo;
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule

@@ hdl/qpht_ram.sv @@
// Table storage: one write port and one read port, read data registered.
// Depends on nothing; word width and depth come from the instantiating module.
module qpht_ram #(
    parameter int SLOTS = 16,
    parameter int W     = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(SLOTS)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(SLOTS)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [SLOTS];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/quadratic_probe_hash_table.sv @@
// Quadratic probing hash table top level: control sequencer and probe walk.
// Depends on qpht_pkg, qpht_mod and qpht_ram.
//
// A word is accepted on a rising edge where start is high and busy is low.
// kind selects insert or search of key. Each word gives exactly one result
// word on o_word, marked by o_valid for a single cycle; the receiver cannot
// stall, so results are never held back.
// The home slot unit reduces the key modulo SLOTS by a constant reciprocal
// multiplication, registering the quotient's low bits and then the remainder.
// The probe walk then issues one table read per cycle to the single read
// port and checks each returned word in the following cycle. A walk takes
// 1 to SLOTS probes; o_valid rises and busy falls in the same cycle, so a
// new word can follow immediately.
// An insert writes the key in the cycle its empty slot is found.
// The single table read port limits the walk to one probe per cycle.
// After reset the block runs a clearing pass, writing zero to every slot,
// with busy held high until it finishes.
module quadratic_probe_hash_table #(
    parameter int SLOTS = qpht_pkg::SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  qpht_pkg::t_in  i_word,
    output logic           o_valid,
    output qpht_pkg::t_out o_word
);
    import qpht_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [AW:0]   SLOTS_E = (AW + 1)'(SLOTS);
    localparam logic [AW-1:0] LAST    = AW'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_pos;
    logic [AW-1:0]    r_d;
    logic [CW-1:0]    r_icnt;
    logic             r_rv;
    logic             r_rlast;
    logic [AW-1:0]    r_rpos;
    logic             r_kind;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_want;
    logic             r_valid;
    t_out             r_out;

    logic             accept;
    logic             mod_done;
    logic [AW-1:0]    mod_home;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [KEY_W-1:0] ram_rdata;
    logic             hit;
    logic             miss;
    logic [AW:0]      pos_sum;
    logic [AW:0]      d_sum;
    logic [AW-1:0]    n_pos;
    logic [AW-1:0]    n_d;
    logic [AW+SLOT_FIELD_W-1:0] slot_ext;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    qpht_mod #(.SLOTS(SLOTS)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (i_word.key),
        .o_done  (mod_done),
        .o_home  (mod_home)
    );

    qpht_ram #(.SLOTS(SLOTS), .W(KEY_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        hit  = r_rv && (ram_rdata == r_want);
        miss = r_rv && !hit && r_rlast;

        pos_sum = {1'b0, r_pos} + {1'b0, r_d};
        if (pos_sum >= SLOTS_E) begin
            pos_sum = pos_sum - SLOTS_E;
        end
        n_pos = pos_sum[AW-1:0];

        d_sum = {1'b0, r_d} + (AW + 1)'(2);
        if (d_sum >= SLOTS_E) begin
            d_sum = d_sum - SLOTS_E;
        end
        n_d = d_sum[AW-1:0];

        slot_ext = {{SLOT_FIELD_W{1'b0}}, r_rpos};

        ram_we    = (r_state == S_CLEAR) ||
                    ((r_state == S_PROBE) && hit && (r_kind == KIND_INSERT));
        ram_waddr = (r_state == S_CLEAR) ? r_pos : r_rpos;
        ram_wdata = (r_state == S_CLEAR) ? '0 : r_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pos   <= '0;
            r_icnt  <= '0;
            r_rv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_kind  <= i_word.kind;
                        r_key   <= i_word.key;
                        r_want  <= (i_word.kind == KIND_SEARCH) ? i_word.key : '0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_pos   <= mod_home;
                        r_d     <= AW'(1);
                        r_icnt  <= '0;
                        r_rv    <= 1'b0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_icnt < CW'(SLOTS)) begin
                        r_rv    <= 1'b1;
                        r_rpos  <= r_pos;
                        r_rlast <= (r_icnt == CW'(SLOTS - 1));
                        r_pos   <= n_pos;
                        r_d     <= n_d;
                        r_icnt  <= r_icnt + 1'b1;
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (hit || miss) begin
                        r_valid <= 1'b1;
                        r_rv    <= 1'b0;
                        r_state <= S_IDLE;
                        if (hit) begin
                            r_out.status <= (r_kind == KIND_INSERT) ? ST_INSERTED : ST_FOUND;
                            r_out.slot   <= slot_ext[SLOT_FIELD_W-1:0];
                        end else begin
                            r_out.status <= (r_kind == KIND_INSERT) ? ST_FULL : ST_ABSENT;
                            r_out.slot   <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_out;

    a_valid_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_PROBE))
        else $error("Result word without a preceding probe walk.");

    a_write_in_clear_or_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_CLEAR) || (r_state == S_PROBE)))
        else $error("Table written outside clearing or probing.");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_word.status == ST_FULL) || (o_word.status == ST_ABSENT)))
        |-> (o_word.slot == '0))
        else $error("Failed operation reports a nonzero slot.");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_icnt <= CW'(SLOTS)))
        else $error("Probe count ran past the table size.");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for quadratic_probe_hash_table: directed and random
// insert and search words, checked against a predicted copy of the table.
// Depends on qpht_pkg and the RTL under hdl.
import qpht_pkg::*;

class hash_scoreboard;
    logic [KEY_W-1:0] slot_keys[SLOTS_DEF];
    t_out             expected_q[$];
    int               errors;

    function new();
        foreach (slot_keys[i]) slot_keys[i] = '0;
        errors = 0;
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endfunction

    function void note_input(t_in w);
        int unsigned      home;
        int unsigned      pos;
        int unsigned      hit;
        logic [KEY_W-1:0] want;
        t_out             res;
        home = int'(w.key) % SLOTS_DEF;
        want = (w.kind == KIND_INSERT) ? '0 : w.key;
        hit  = SLOTS_DEF;
        for (int unsigned i = 0; i < SLOTS_DEF; i++) begin
            pos = (home + i * i) % SLOTS_DEF;
            if (hit == SLOTS_DEF && slot_keys[pos] == want) hit = pos;
        end
        res.slot = '0;
        if (w.kind == KIND_INSERT) begin
            if (hit < SLOTS_DEF) begin
                slot_keys[hit] = w.key;
                res.status = ST_INSERTED;
                res.slot = hit[SLOT_FIELD_W-1:0];
            end else begin
                res.status = ST_FULL;
            end
        end else begin
            if (hit < SLOTS_DEF) begin
                res.status = ST_FOUND;
                res.slot = hit[SLOT_FIELD_W-1:0];
            end else begin
                res.status = ST_ABSENT;
            end
        end
        expected_q.push_back(res);
    endfunction

    function void check_result(t_out got);
        t_out want;
        if (expected_q.size() == 0) begin
            flag($sformatf("unexpected result: status %0d slot %0d", got.status, got.slot));
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status || got.slot !== want.slot) begin
            flag($sformatf("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                           want.status, want.slot, got.status, got.slot));
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_word;
    logic o_valid;
    t_out o_word;

    hash_scoreboard   sb = new();
    logic [KEY_W-1:0] key_pool[$];
    int               sender_idle_pct;
    int               cycle_count = 0;

    quadratic_probe_hash_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) sb.note_input(i_word);
        if (i_rst_n === 1'b1 && o_valid === 1'b1) sb.check_result(o_word);
    end

    task automatic send_word(input logic k, input logic [KEY_W-1:0] key);
        int gap;
        i_word <= t_in'{kind: k, key: key};
        start  <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (k == KIND_INSERT && key != '0) key_pool.push_back(key);
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [KEY_W-1:0] pool_key();
        if (key_pool.size() == 0) return KEY_W'($urandom_range(1, 63));
        return key_pool[$urandom_range(key_pool.size() - 1)];
    endfunction

    task automatic send_random();
        int r;
        r = $urandom_range(99);
        if (r < 2)       send_word(KIND_INSERT, KEY_W'($urandom));
        else if (r < 3)  send_word(KIND_INSERT, pool_key());
        else if (r < 8)  send_word(KIND_INSERT, '0);
        else if (r < 55) send_word(KIND_SEARCH, pool_key());
        else if (r < 80) send_word(KIND_SEARCH, KEY_W'($urandom));
        else if (r < 90) send_word(KIND_SEARCH, KEY_W'($urandom_range(0, 63)));
        else             send_word(KIND_SEARCH, '0);
    endtask

    initial begin
        int drain;
        start   <= 1'b0;
        i_word  <= '0;
        i_rst_n <= 1'b0;
        sender_idle_pct = 23;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(KIND_SEARCH, 31'd0);
        send_word(KIND_SEARCH, 31'd5);
        send_word(KIND_INSERT, 31'd0);
        send_word(KIND_INSERT, 31'h7FFF_FFFF);
        send_word(KIND_SEARCH, 31'h7FFF_FFFF);
        send_word(KIND_INSERT, 31'h4000_0000);
        send_word(KIND_INSERT, 31'd3);
        send_word(KIND_INSERT, 31'd19);
        send_word(KIND_INSERT, 31'd35);
        send_word(KIND_INSERT, 31'd51);
        send_word(KIND_INSERT, 31'd67);
        send_word(KIND_SEARCH, 31'd51);
        send_word(KIND_SEARCH, 31'd67);
        send_word(KIND_SEARCH, 31'd0);
        send_word(KIND_INSERT, 31'd20);
        send_word(KIND_INSERT, 31'd20);
        send_word(KIND_SEARCH, 31'd20);
        send_word(KIND_INSERT, 31'd16);
        send_word(KIND_INSERT, 31'd32);
        send_word(KIND_SEARCH, 31'd0);
        send_word(KIND_INSERT, 31'd0);
        send_word(KIND_INSERT, 31'h2AAA_AAAA);
        send_word(KIND_SEARCH, 31'h5555_5555);

        repeat (400) send_random();
        sender_idle_pct = 63;
        repeat (400) send_random();
        sender_idle_pct = 0;
        repeat (400) send_random();
        start <= 1'b0;

        drain = 0;
        while (sb.expected_q.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (40) @(posedge i_clk);
        sb.errors += sb.expected_q.size();
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
